// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion shorthands shared by the design; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication: when ante holds, cons must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: %m");
// Next-cycle implication: when ante holds, cons must hold at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: %m");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- design/tcw_pkg.sv -----
// ---------------------------------------------------------------------------
// tcw_pkg
// Field widths, command and register codes, and character constants of the
// text console writer.
// ---------------------------------------------------------------------------
package tcw_pkg;

   localparam int CMD_W      = 2;
   localparam int CHAR_W     = 8;
   localparam int COL_W      = 7;
   localparam int ROW_W      = 5;
   localparam int ATTR_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTR   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_ATTR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CURSOR_EN   = 2'd2;

   localparam logic [ATTR_W-1:0] TEXT_ATTR_RESET   = 8'd7;
   localparam logic [ATTR_W-1:0] CURSOR_ATTR_RESET = 8'd112;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   typedef struct packed {
      logic [COL_W-1:0]  cursor_column;
      logic [ROW_W-1:0]  cursor_row;
      logic [CHAR_W-1:0] cell_char;
      logic [ATTR_W-1:0] cell_attribute;
   } rsp_data_type;

endpackage

// ----- design/tcw_if.sv -----
// ---------------------------------------------------------------------------
// tcw_if
// Valid/ready channel interfaces for commands and results.
// ---------------------------------------------------------------------------
interface tcw_req_if;
   import tcw_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [CHAR_W-1:0] char_code;
   logic [COL_W-1:0]  read_column;
   logic [ROW_W-1:0]  read_row;

   modport source (output valid, command, char_code, read_column, read_row,
                   input ready);
   modport sink   (input valid, command, char_code, read_column, read_row,
                   output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;

   logic              valid;
   logic              ready;
   logic [COL_W-1:0]  cursor_column;
   logic [ROW_W-1:0]  cursor_row;
   logic [CHAR_W-1:0] cell_char;
   logic [ATTR_W-1:0] cell_attribute;

   modport source (output valid, cursor_column, cursor_row, cell_char, cell_attribute,
                   input ready);
   modport sink   (input valid, cursor_column, cursor_row, cell_char, cell_attribute,
                   output ready);
endinterface

// ----- design/tcw_cursor_step.sv -----
// ---------------------------------------------------------------------------
// tcw_cursor_step
// Next cursor position for a put, and whether the screen has to scroll.
// ---------------------------------------------------------------------------
module tcw_cursor_step #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic [$clog2(SCREEN_COLUMNS)-1:0] col,
   input  logic [$clog2(SCREEN_ROWS)-1:0]    row,
   input  logic [tcw_pkg::CHAR_W-1:0]        char_code,
   output logic [$clog2(SCREEN_COLUMNS)-1:0] next_col,
   output logic [$clog2(SCREEN_ROWS)-1:0]    next_row,
   output logic                              newline,
   output logic                              scroll
);
   import tcw_pkg::*;

   localparam int CW = $clog2(SCREEN_COLUMNS);
   localparam int RW = $clog2(SCREEN_ROWS);

   logic last_col;
   logic last_row;

   assign newline  = (char_code == CH_NEWLINE) || (char_code == CH_RETURN);
   assign last_col = (col == CW'(SCREEN_COLUMNS - 1));
   assign last_row = (row == RW'(SCREEN_ROWS - 1));

   // A newline and a write into the last column both end the row; on the
   // last row that scrolls the screen and the cursor stays on that row.
   always_comb begin
      next_col = col + CW'(1);
      next_row = row;
      scroll   = 1'b0;
      if (newline || last_col) begin
         next_col = '0;
         if (last_row) begin
            scroll = 1'b1;
         end else begin
            next_row = row + RW'(1);
         end
      end
   end

endmodule

// ----- design/text_console_writer_unit.sv -----
// ---------------------------------------------------------------------------
// text_console_writer_unit
// Text screen of character and attribute cells with a cursor, driven by
// put, clear and read commands over valid/ready channels.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  req_port  in         command, char_code, read_column, read_row
//  rsp_port  out        cursor_column, cursor_row, cell_char, cell_attribute
//  csr_*     in         register writes: text/cursor attribute, cursor enable
//
// A put or read goes through the transfer cycle and then ST_PUT2, which paints the
// new cursor cell (put), or ST_READ, which takes the registered memory read (read).
// A put that scrolls sweeps the character memory and a clear sweeps both
// memories, over all CELLS = SCREEN_COLUMNS * SCREEN_ROWS cells, one cell per
// cycle through their single write port.
// After reset a clearing pass zeroes both memories; no command transfer is
// taken during it. A stalled result sits in the output register, and the next
// command may be taken meanwhile; its result then waits in a holding register
// until the output register frees.
//
`include "assert_macros.svh"

module text_console_writer_unit #(
   parameter int SCREEN_COLUMNS = 80,
   parameter int SCREEN_ROWS    = 25
) (
   input  logic                           clock,
   input  logic                           reset,
   tcw_req_if.sink                        req_port,
   tcw_rsp_if.source                      rsp_port,
   input  logic                           csr_write_enable,
   input  logic [tcw_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tcw_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import tcw_pkg::*;

   localparam int CELLS = SCREEN_COLUMNS * SCREEN_ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int CW    = $clog2(SCREEN_COLUMNS);
   localparam int RW    = $clog2(SCREEN_ROWS);

   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0] MOVE_END  = AW'(CELLS - SCREEN_COLUMNS);
   localparam logic [AW-1:0] COLS_A    = AW'(SCREEN_COLUMNS);

   // One-hot sequencer states.
   typedef enum logic [7:0] {
      ST_INIT   = 8'b0000_0001,
      ST_IDLE   = 8'b0000_0010,
      ST_PUT2   = 8'b0000_0100,
      ST_SCROLL = 8'b0000_1000,
      ST_SCEND  = 8'b0001_0000,
      ST_CLEAR  = 8'b0010_0000,
      ST_READ   = 8'b0100_0000,
      ST_WAIT   = 8'b1000_0000
   } state_type;

   // Screen memories: characters and attributes are kept apart, because a
   // scroll moves characters only and a put paints attributes on two cells.
   logic [CHAR_W-1:0] char_mem [CELLS];
   logic [ATTR_W-1:0] attr_mem [CELLS];

   state_type         state_ff, state_in;
   logic [AW-1:0]     sc_ff, sc_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [RW-1:0]     row_ff, row_in;
   logic              scroll_ff, scroll_in;
   logic              wr_v_ff, wr_v_in;
   logic [AW-1:0]     wr_addr_ff, wr_addr_in;
   logic              wr_zero_ff, wr_zero_in;
   logic [ATTR_W-1:0] text_attr_ff;
   logic [ATTR_W-1:0] cursor_attr_ff;
   logic              cursor_en_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_data_type      rsp_data_ff, rsp_data_in;
   rsp_data_type      pend_ff, pend_in;
   logic [CHAR_W-1:0] char_rdata_ff;
   logic [ATTR_W-1:0] attr_rdata_ff;

   logic              char_we;
   logic [AW-1:0]     char_waddr;
   logic [CHAR_W-1:0] char_wdata;
   logic [AW-1:0]     char_raddr;
   logic              attr_we;
   logic [AW-1:0]     attr_waddr;
   logic [ATTR_W-1:0] attr_wdata;

   logic              req_acc;
   logic              out_free;
   logic              fin;
   rsp_data_type      fin_data;
   logic [AW-1:0]     cur_addr;
   logic [AW-1:0]     rd_addr;
   logic [CW-1:0]     rd_col;
   logic [RW-1:0]     rd_row;
   logic [CW-1:0]     step_col;
   logic [RW-1:0]     step_row;
   logic              step_newline;
   logic              step_scroll;
   logic              cursor_ok;

   tcw_cursor_step #(
      .SCREEN_COLUMNS (SCREEN_COLUMNS),
      .SCREEN_ROWS    (SCREEN_ROWS)
   ) u_step (
      .col       (col_ff),
      .row       (row_ff),
      .char_code (req_port.char_code),
      .next_col  (step_col),
      .next_row  (step_row),
      .newline   (step_newline),
      .scroll    (step_scroll)
   );

   assign req_acc  = req_port.valid && req_port.ready;
   assign out_free = !rsp_valid_ff || rsp_port.ready;

   // Linear cell address of the cursor, row-major.
   assign cur_addr = AW'(AW'(row_ff) * COLS_A) + AW'(col_ff);

   // Read coordinates beyond the screen saturate to the last column or row.
   assign rd_col  = (8'(req_port.read_column) >= 8'(SCREEN_COLUMNS)) ?
                    CW'(SCREEN_COLUMNS - 1) : CW'(req_port.read_column);
   assign rd_row  = (8'(req_port.read_row) >= 8'(SCREEN_ROWS)) ?
                    RW'(SCREEN_ROWS - 1) : RW'(req_port.read_row);
   assign rd_addr = AW'(AW'(rd_row) * COLS_A) + AW'(rd_col);

   always_comb begin
      state_in   = state_ff;
      sc_in      = sc_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      scroll_in  = scroll_ff;
      wr_v_in    = 1'b0;
      wr_addr_in = sc_ff;
      wr_zero_in = (sc_ff >= MOVE_END);
      pend_in    = pend_ff;
      char_we    = 1'b0;
      char_waddr = cur_addr;
      char_wdata = req_port.char_code;
      char_raddr = rd_addr;
      attr_we    = 1'b0;
      attr_waddr = cur_addr;
      attr_wdata = text_attr_ff;
      fin        = 1'b0;
      fin_data   = '{cursor_column: COL_W'(col_ff), cursor_row: ROW_W'(row_ff),
                     cell_char: '0, cell_attribute: '0};
      req_port.ready = 1'b0;

      // The scroll sweep reads one row ahead and writes the character back in the
      // following cycle; the bottom row is written with zero.
      if (wr_v_ff) begin
         char_we    = 1'b1;
         char_waddr = wr_addr_ff;
         char_wdata = wr_zero_ff ? '0 : char_rdata_ff;
      end

      case (state_ff)
         ST_INIT: begin
            char_we    = 1'b1;
            char_waddr = sc_ff;
            char_wdata = '0;
            attr_we    = 1'b1;
            attr_waddr = sc_ff;
            attr_wdata = '0;
            sc_in      = sc_ff + AW'(1);
            if (sc_ff == LAST_CELL) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_port.ready = 1'b1;
            if (req_acc) begin
               case (req_port.command)
                  CMD_PUT: begin
                     // The old cursor cell takes the text attribute; a
                     // newline keeps the character that is there.
                     attr_we   = 1'b1;
                     char_we   = !step_newline;
                     col_in    = step_col;
                     row_in    = step_row;
                     scroll_in = step_scroll;
                     state_in  = ST_PUT2;
                  end
                  CMD_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     sc_in    = '0;
                     state_in = ST_CLEAR;
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_PUT2: begin
            // The cursor registers now hold the new position; paint it.
            attr_we = 1'b1;
            if (scroll_ff) begin
               sc_in    = '0;
               state_in = ST_SCROLL;
            end else begin
               fin = 1'b1;
            end
         end
         ST_SCROLL: begin
            char_raddr = sc_ff + COLS_A;
            wr_v_in    = 1'b1;
            sc_in      = sc_ff + AW'(1);
            if (sc_ff == LAST_CELL) begin
               state_in = ST_SCEND;
            end
         end
         ST_SCEND: begin
            fin = 1'b1;
         end
         ST_CLEAR: begin
            char_we    = 1'b1;
            char_waddr = sc_ff;
            char_wdata = CH_SPACE;
            attr_we    = 1'b1;
            attr_waddr = sc_ff;
            attr_wdata = ((sc_ff == '0) && cursor_en_ff) ? cursor_attr_ff : text_attr_ff;
            sc_in      = sc_ff + AW'(1);
            if (sc_ff == LAST_CELL) begin
               fin = 1'b1;
            end
         end
         ST_READ: begin
            fin                     = 1'b1;
            fin_data.cell_char      = char_rdata_ff;
            fin_data.cell_attribute = attr_rdata_ff;
         end
         ST_WAIT: begin
            fin      = 1'b1;
            fin_data = pend_ff;
         end
         default: begin
            sc_in    = '0;
            state_in = ST_INIT;
         end
      endcase

      // A finished result goes straight to the output register when it is
      // free, and otherwise waits in the holding register.
      if (fin) begin
         if (out_free) begin
            state_in = ST_IDLE;
         end else begin
            state_in = ST_WAIT;
            pend_in  = fin_data;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin_data;
      end
   end

   assign rsp_port.valid          = rsp_valid_ff;
   assign rsp_port.cursor_column  = rsp_data_ff.cursor_column;
   assign rsp_port.cursor_row     = rsp_data_ff.cursor_row;
   assign rsp_port.cell_char      = rsp_data_ff.cell_char;
   assign rsp_port.cell_attribute = rsp_data_ff.cell_attribute;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sc_ff        <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         scroll_ff    <= 1'b0;
         wr_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sc_ff        <= sc_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         scroll_ff    <= scroll_in;
         wr_v_ff      <= wr_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         text_attr_ff   <= TEXT_ATTR_RESET;
         cursor_attr_ff <= CURSOR_ATTR_RESET;
         cursor_en_ff   <= 1'b1;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TEXT_ATTR:   text_attr_ff   <= csr_write_data[ATTR_W-1:0];
            CSR_CURSOR_ATTR: cursor_attr_ff <= csr_write_data[ATTR_W-1:0];
            CSR_CURSOR_EN:   cursor_en_ff   <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      wr_zero_ff  <= wr_zero_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Screen memories, one write and one registered read per cycle each.
   always_ff @(posedge clock) begin
      if (char_we) begin
         char_mem[char_waddr] <= char_wdata;
      end
      char_rdata_ff <= char_mem[char_raddr];
   end

   always_ff @(posedge clock) begin
      if (attr_we) begin
         attr_mem[attr_waddr] <= attr_wdata;
      end
      attr_rdata_ff <= attr_mem[rd_addr];
   end

   assign cursor_ok = (int'(col_ff) < SCREEN_COLUMNS) && (int'(row_ff) < SCREEN_ROWS);

   // The cursor never leaves the screen.
   `ASSERT_IMPLIES(a_cursor_range, clock, reset, 1'b1, cursor_ok)
   // A scroll write-back never meets a command transfer on the write port.
   `ASSERT_IMPLIES(a_pipe_quiet, clock, reset, wr_v_ff, !req_acc)
   // A finished result with a free output register is offered next cycle.
   `ASSERT_NEXT(a_rsp_load, clock, reset, fin && out_free, rsp_valid_ff)

endmodule

// ----- tb/sv/tb.sv -----
// ---------------------------------------------------------------------------
// tb - text console writer testbench
// Drives put, clear, read and unused commands into the console, keeps its own
// copy of the screen, cursor and attribute registers, and checks every returned
// status word against that copy, field by field.
// ---------------------------------------------------------------------------
module tb;
   import tcw_pkg::*;

   localparam int COLS  = 80;
   localparam int ROWS  = 25;
   localparam int CELLS = COLS * ROWS;

   // Command code that the console does not use; it must change nothing.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // Chance, in percent, that a side holds off.
   localparam int IDLE_PERCENT = 13;

   // Number of randomised phases and commands in each of them.
   localparam int PHASES         = 8;
   localparam int PHASE_COMMANDS = 240;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [CHAR_W-1:0] char_code;
      logic [COL_W-1:0]  read_column;
      logic [ROW_W-1:0]  read_row;
   } console_cmd_type;

   logic clock;
   logic reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   tcw_req_if req_if ();
   tcw_rsp_if rsp_if ();

   text_console_writer_unit #(
      .SCREEN_COLUMNS (COLS),
      .SCREEN_ROWS    (ROWS)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_port         (req_if),
      .rsp_port         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Our own view of the console: every cell, the cursor and the registers.
   logic [15:0]       shadow_screen [CELLS];
   int                cursor_col;
   int                cursor_row;
   logic [ATTR_W-1:0] text_attr;
   logic [ATTR_W-1:0] cursor_attr;
   logic              cursor_paint_en;

   // Status words still owed by the console, oldest first.
   rsp_data_type expected_status [$];

   int  failures;
   int  commands_sent;
   // When set, neither side inserts any idle cycles.
   bit  calm_traffic;

   // -----------------------------------------------------------------------
   // Clock and overall time limit
   // -----------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The limit is set above the time a run would need even if every command
   // scrolled or cleared the whole screen.
   initial begin
      #250_000_000;
      $display("[text_console_writer_unit] ERROR");
      $finish;
   end

   // -----------------------------------------------------------------------
   // Screen prediction
   // -----------------------------------------------------------------------
   function automatic int cell_at(int col, int row);
      if (col >= COLS) col = COLS - 1;
      if (row >= ROWS) row = ROWS - 1;
      return row * COLS + col;
   endfunction

   function automatic void paint_attribute(int col, int row, logic [ATTR_W-1:0] attr);
      int idx;
      idx = cell_at(col, row);
      shadow_screen[idx][15:8] = attr;
   endfunction

   // Only character bytes move up; the attribute bytes stay where they are,
   // and the bottom row is left with zero characters.
   function automatic void scroll_screen();
      for (int i = 0; i < CELLS - COLS; i++) begin
         shadow_screen[i][7:0] = shadow_screen[i + COLS][7:0];
      end
      for (int i = CELLS - COLS; i < CELLS; i++) begin
         shadow_screen[i][7:0] = 8'h00;
      end
   endfunction

   function automatic void put_on_screen(logic [CHAR_W-1:0] ch);
      int col;
      int row;
      col = cursor_col;
      row = cursor_row;
      if (ch == CH_NEWLINE || ch == CH_RETURN) begin
         // A line break repaints the cell it leaves but keeps its character.
         paint_attribute(col, row, text_attr);
         row++;
         if (row >= ROWS) begin
            scroll_screen();
            row = ROWS - 1;
         end
         col = 0;
      end else begin
         shadow_screen[cell_at(col, row)] = {text_attr, ch};
         col++;
      end
      if (col >= COLS) begin
         col = 0;
         if (row >= ROWS - 1) begin
            scroll_screen();
            row = ROWS - 1;
         end else begin
            row++;
         end
      end
      cursor_col = col;
      cursor_row = row;
      // The new cursor cell always ends up with the text attribute.
      paint_attribute(col, row, text_attr);
   endfunction

   function automatic rsp_data_type predict_status(console_cmd_type c);
      rsp_data_type status;
      int           idx;
      status = '0;
      case (c.command)
         CMD_PUT: begin
            put_on_screen(c.char_code);
         end
         CMD_CLEAR: begin
            for (int i = 0; i < CELLS; i++) shadow_screen[i] = {text_attr, CH_SPACE};
            cursor_col = 0;
            cursor_row = 0;
            paint_attribute(0, 0, cursor_paint_en ? cursor_attr : text_attr);
         end
         CMD_READ: begin
            idx = cell_at(int'(c.read_column), int'(c.read_row));
            status.cell_char      = shadow_screen[idx][7:0];
            status.cell_attribute = shadow_screen[idx][15:8];
         end
         default: begin
         end
      endcase
      status.cursor_column = cursor_col[COL_W-1:0];
      status.cursor_row    = cursor_row[ROW_W-1:0];
      return status;
   endfunction

   // -----------------------------------------------------------------------
   // Result side: random back-pressure and the checker
   // -----------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= calm_traffic || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   // Every transfer on the result channel is matched against the oldest
   // outstanding prediction. Sampling happens at the edge, before any of the
   // nonblocking updates of this step land, so the order of processes within
   // the step does not matter.
   always @(posedge clock) begin : check_status
      rsp_data_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_status.size() == 0) begin
            $error("status transfer with nothing outstanding: col %0d row %0d",
                   rsp_if.cursor_column, rsp_if.cursor_row);
            failures++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_if.cursor_column !== want.cursor_column) begin
               $error("cursor_column: expected %0d, got %0d",
                      want.cursor_column, rsp_if.cursor_column);
               failures++;
            end
            if (rsp_if.cursor_row !== want.cursor_row) begin
               $error("cursor_row: expected %0d, got %0d",
                      want.cursor_row, rsp_if.cursor_row);
               failures++;
            end
            if (rsp_if.cell_char !== want.cell_char) begin
               $error("cell_char: expected 0x%02h, got 0x%02h",
                      want.cell_char, rsp_if.cell_char);
               failures++;
            end
            if (rsp_if.cell_attribute !== want.cell_attribute) begin
               $error("cell_attribute: expected 0x%02h, got 0x%02h",
                      want.cell_attribute, rsp_if.cell_attribute);
               failures++;
            end
         end
      end
   end

   // -----------------------------------------------------------------------
   // Command side
   // -----------------------------------------------------------------------
   // Sends one command and records what the console should answer. Valid is
   // left high on return so that a following command can go out back to back;
   // it is only lowered on an idle cycle or when traffic stops.
   task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [CHAR_W-1:0] ch,
                               input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      console_cmd_type c;
      c = '{command: cmd, char_code: ch, read_column: col, read_row: row};
      while (!calm_traffic && $urandom_range(99) < IDLE_PERCENT) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.command     <= c.command;
      req_if.char_code   <= c.char_code;
      req_if.read_column <= c.read_column;
      req_if.read_row    <= c.read_row;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      // The transfer happened at this edge.
      expected_status.push_back(predict_status(c));
      commands_sent++;
   endtask

   task automatic send_put(input logic [CHAR_W-1:0] ch);
      send_command(CMD_PUT, ch, COL_W'($urandom), ROW_W'($urandom));
   endtask

   task automatic send_read(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row);
      send_command(CMD_READ, CHAR_W'($urandom), col, row);
   endtask

   task automatic send_clear();
      send_command(CMD_CLEAR, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
   endtask

   task automatic send_random_command();
      send_command(CMD_W'($urandom), CHAR_W'($urandom), COL_W'($urandom),
                   ROW_W'($urandom));
   endtask

   function automatic logic [CHAR_W-1:0] printable_char();
      logic [CHAR_W-1:0] ch;
      do ch = CHAR_W'($urandom_range(255)); while (ch == CH_NEWLINE || ch == CH_RETURN);
      return ch;
   endfunction

   // Stops the command stream and waits until every status word is back.
   // The few extra cycles let the final paint of a put settle before any
   // register is touched.
   task automatic drain_console();
      req_if.valid <= 1'b0;
      while (expected_status.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Writes all three registers, one per cycle, and mirrors them locally.
   task automatic set_attributes(input logic [ATTR_W-1:0] text, input logic [ATTR_W-1:0] cur,
                                 input logic [CSR_DATA_W-1:0] enable_word);
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_TEXT_ATTR;
      csr_write_data   <= text;
      @(posedge clock);
      csr_index        <= CSR_CURSOR_ATTR;
      csr_write_data   <= cur;
      @(posedge clock);
      csr_index        <= CSR_CURSOR_EN;
      csr_write_data   <= enable_word;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      text_attr       = text;
      cursor_attr     = cur;
      cursor_paint_en = enable_word[0];
      @(posedge clock);
   endtask

   // -----------------------------------------------------------------------
   // Tests
   // -----------------------------------------------------------------------
   // Runs with the register values left by reset: reads of the zeroed
   // screen, ordinary characters, both line breaks, the character extremes,
   // saturating reads, the unused command and a clear.
   task automatic test_reset_defaults();
      send_read(0, 0);
      send_put(8'h41);
      send_read(0, 0);
      send_read(1, 0);
      send_put(CH_NEWLINE);
      send_put(CH_RETURN);
      send_put(8'h00);
      send_put(8'hFF);
      send_read(7'd127, 5'd31);
      send_read(COL_W'(COLS - 1), ROW_W'(ROWS - 1));
      send_command(CMD_UNUSED, CHAR_W'($urandom), COL_W'($urandom), ROW_W'($urandom));
      send_clear();
      send_read(0, 0);
      send_read(COL_W'(COLS - 1), ROW_W'(ROWS - 1));
      send_put(CH_SPACE);
      drain_console();
   endtask

   // Register extremes, with the cursor paint both off and on after a clear.
   // The enable word carries high bits that must be ignored.
   task automatic test_register_extremes();
      set_attributes(8'hFF, 8'h00, 8'hFE);
      send_clear();
      send_read(0, 0);
      send_put(8'h7F);
      send_read(0, 0);
      send_read(1, 0);
      drain_console();
      set_attributes(8'h00, 8'hFF, 8'h01);
      send_clear();
      send_read(0, 0);
      send_read(COL_W'(COLS / 2), ROW_W'(ROWS / 2));
      send_put(CH_NEWLINE);
      send_read(0, 0);
      drain_console();
   endtask

   // Mostly well-formed text: lines of printable characters ended by a line
   // break, runs of line breaks that push the cursor to the bottom and keep
   // the screen scrolling, reads scattered over the screen and past its edge,
   // the occasional clear, and a little raw noise on every field.
   task automatic run_console_traffic(input int how_many);
      int target;
      int pick;
      int len;
      target = commands_sent + how_many;
      while (commands_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 5) begin
            send_clear();
         end else if (pick < 45) begin
            // A full line, one short of it, or a short one. A full line on
            // the bottom row ends by filling the bottom-right cell.
            case ($urandom_range(9))
               0:       len = COLS;
               1:       len = COLS - 1;
               default: len = $urandom_range(20);
            endcase
            for (int i = 0; i < len; i++) begin
               send_put(printable_char());
               if ($urandom_range(99) < 20)
                  send_read(COL_W'($urandom_range(COLS - 1)),
                            ROW_W'($urandom_range(ROWS - 1)));
            end
            if ($urandom_range(9) != 0) send_put($urandom_range(1) ? CH_NEWLINE : CH_RETURN);
         end else if (pick < 65) begin
            len = $urandom_range(6, 1);
            for (int i = 0; i < len; i++) send_put($urandom_range(1) ? CH_NEWLINE : CH_RETURN);
         end else if (pick < 85) begin
            len = $urandom_range(4, 1);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(4) == 0) send_read(COL_W'($urandom), ROW_W'($urandom));
               else send_read(COL_W'($urandom_range(COLS - 1)),
                              ROW_W'($urandom_range(ROWS - 1)));
            end
         end else begin
            len = $urandom_range(3, 1);
            for (int i = 0; i < len; i++) send_random_command();
         end
      end
   endtask

   // Random traffic in phases, each under a different register setting. The
   // first two phases take the extremes; one phase runs with no idling on
   // either side.
   task automatic test_random_phases();
      for (int p = 0; p < PHASES; p++) begin
         drain_console();
         case (p)
            0:       set_attributes(8'h00, 8'h00, 8'h00);
            1:       set_attributes(8'hFF, 8'hFF, 8'hFF);
            default: set_attributes(ATTR_W'($urandom), ATTR_W'($urandom),
                                    CSR_DATA_W'($urandom));
         endcase
         calm_traffic = (p == 3);
         run_console_traffic(PHASE_COMMANDS);
      end
      calm_traffic = 1'b0;
   endtask

   // -----------------------------------------------------------------------
   // Main sequence
   // -----------------------------------------------------------------------
   initial begin
      failures        = 0;
      commands_sent   = 0;
      calm_traffic    = 1'b0;
      cursor_col      = 0;
      cursor_row      = 0;
      text_attr       = TEXT_ATTR_RESET;
      cursor_attr     = CURSOR_ATTR_RESET;
      cursor_paint_en = 1'b1;
      for (int i = 0; i < CELLS; i++) shadow_screen[i] = 16'h0000;

      reset              <= 1'b1;
      csr_write_enable   <= 1'b0;
      csr_index          <= CSR_TEXT_ATTR;
      csr_write_data     <= '0;
      req_if.valid       <= 1'b0;
      req_if.command     <= CMD_PUT;
      req_if.char_code   <= '0;
      req_if.read_column <= '0;
      req_if.read_row    <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // The console wipes its memories after reset and holds off commands
      // meanwhile; the first send simply waits for it.
      test_reset_defaults();
      test_register_extremes();
      test_random_phases();

      drain_console();
      // Give any stray transfer time to show up after a full screen sweep.
      repeat (CELLS + 10) @(posedge clock);
      if (failures == 0) begin
         $display("[text_console_writer_unit] OK");
      end else begin
         $display("[text_console_writer_unit] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+design
design/tcw_pkg.sv
design/tcw_if.sv
design/tcw_cursor_step.sv
design/text_console_writer_unit.sv
tb/sv/tb.sv
